// File: rtl/core/srtf_pkg.sv
// Shared types and constants for the shortest-remaining-time-first scheduler.
`default_nettype none

package srtf_pkg;

    localparam int TIME_W = 16;
    localparam int ID_W   = 8;
    localparam int TOTAL_W = 32;

    // Operation codes that every cell of the sorted list obeys.
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_POP    = 2'd2;
    localparam logic [1:0] CELL_DEC    = 2'd3;

    // One list entry: remaining run time and process identifier.
    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Control broadcast to the cells.
    typedef struct packed {
        logic [1:0] op;
        entry_t     new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/srtf_cell.sv
// One cell of the sorted ready list: holds one entry and trades with its neighbors.
`default_nettype none

module srtf_cell (
    input  wire logic               aclk,
    input  wire srtf_pkg::cell_ctrl_t ctrl,
    input  wire logic               occupied,
    input  wire logic               left_keep,
    input  wire srtf_pkg::entry_t   left_data,
    input  wire srtf_pkg::entry_t   right_data,
    output srtf_pkg::entry_t        data,
    output logic                    keep
);
    import srtf_pkg::*;

    entry_t data_reg;
    entry_t data_next;

    // An occupied entry with time not above the arrival stays in place on insert.
    assign keep = occupied && (data_reg.remaining <= ctrl.new_entry.remaining);
    assign data = data_reg;

    // Next entry: hold, take the arrival, shift right on insert, shift left on pop, decrement on dec.
    always_comb begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
                data_next = data_reg;
            end
            CELL_INSERT: begin
                if (keep) begin
                    data_next = data_reg;
                end else if (left_keep) begin
                    data_next = ctrl.new_entry;
                end else begin
                    data_next = left_data;
                end
            end
            CELL_POP: begin
                data_next = right_data;
            end
            CELL_DEC: begin
                data_next.remaining = data_reg.remaining - TIME_W'(1);
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/srtf_scheduler_queue.sv
// Top level of the shortest-remaining-time-first scheduler with its sorted cell chain.
`default_nettype none

// The block keeps up to DEPTH processes in a row of cells sorted by remaining
// time; the head cell is the process that runs. Every input item (an arrival
// or a tick) produces exactly one result item. The whole cell row inserts,
// pops or decrements its head at once, so one item per cycle is sustained
// while the result side keeps m_tready high. A result waits in the output
// register; a new item is taken whenever that register is empty or is being
// emptied in the same cycle. There is no clearing pass after reset; list
// entries are only read once written.
module srtf_scheduler_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: process_id [7:0], burst_time [23:8]
    input  wire logic [23:0] s_tdata,
    // s_tuser: req_type (0 = arrival, 1 = tick)
    input  wire logic        s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: running_valid [0], running_id [8:1], started [9], completed [10],
    //          queue_full [11], total_waiting [43:12], zero [47:44]
    output logic [47:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready
);
    import srtf_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      count_reg, count_next;
    logic               pending_reg, pending_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               m_valid_reg, m_valid_next;
    logic [47:0]        m_data_reg, m_data_next;

    entry_t             cell_data [DEPTH];
    logic [DEPTH-1:0]   cell_keep;
    logic [DEPTH-1:0]   occupied;
    cell_ctrl_t         head_ctrl, body_ctrl;

    logic               accept;
    logic               is_tick;
    entry_t             arrival;
    logic               burst_zero;
    logic               list_full;
    logic               list_empty;
    logic               do_insert;
    logic               do_full;
    logic               do_run;
    logic               head_done;
    logic [TOTAL_W:0]   wait_sum;

    // Input decoding.
    assign accept           = s_tvalid && s_tready;
    assign is_tick          = s_tuser;
    assign arrival.id       = s_tdata[ID_W-1:0];
    assign arrival.remaining = s_tdata[ID_W +: TIME_W];
    assign burst_zero       = (arrival.remaining == '0);
    assign list_full        = (count_reg == CW'(DEPTH));
    assign list_empty       = (count_reg == '0);
    assign do_insert        = accept && !is_tick && !burst_zero && !list_full;
    assign do_full          = accept && !is_tick && !burst_zero && list_full;
    assign do_run           = accept && is_tick && !list_empty;
    assign head_done        = (cell_data[0].remaining == TIME_W'(1));

    assign s_tready = !m_valid_reg || m_tready;

    // Cell operations: the head alone decrements, everyone shifts together.
    always_comb begin
        head_ctrl.new_entry = arrival;
        body_ctrl.new_entry = arrival;
        head_ctrl.op = CELL_HOLD;
        body_ctrl.op = CELL_HOLD;
        if (do_insert) begin
            head_ctrl.op = CELL_INSERT;
            body_ctrl.op = CELL_INSERT;
        end else if (do_run) begin
            if (head_done) begin
                head_ctrl.op = CELL_POP;
                body_ctrl.op = CELL_POP;
            end else begin
                head_ctrl.op = CELL_DEC;
            end
        end
    end

    // The row of cells.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign occupied[gi] = (CW'(gi) < count_reg);
            if (gi == 0) begin : g_head
                srtf_cell u_cell (
                    .aclk       (aclk),
                    .ctrl       (head_ctrl),
                    .occupied   (occupied[gi]),
                    .left_keep  (1'b1),
                    .left_data  (arrival),
                    .right_data (cell_data[gi + 1]),
                    .data       (cell_data[gi]),
                    .keep       (cell_keep[gi])
                );
            end else if (gi == DEPTH - 1) begin : g_tail
                srtf_cell u_cell (
                    .aclk       (aclk),
                    .ctrl       (body_ctrl),
                    .occupied   (occupied[gi]),
                    .left_keep  (cell_keep[gi - 1]),
                    .left_data  (cell_data[gi - 1]),
                    .right_data (arrival),
                    .data       (cell_data[gi]),
                    .keep       (cell_keep[gi])
                );
            end else begin : g_body
                srtf_cell u_cell (
                    .aclk       (aclk),
                    .ctrl       (body_ctrl),
                    .occupied   (occupied[gi]),
                    .left_keep  (cell_keep[gi - 1]),
                    .left_data  (cell_data[gi - 1]),
                    .right_data (cell_data[gi + 1]),
                    .data       (cell_data[gi]),
                    .keep       (cell_keep[gi])
                );
            end
        end
    endgenerate

    // Saturating waiting total: grows by count minus one on a run.
    assign wait_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(count_reg - CW'(1));

    // Control state and result item.
    always_comb begin
        count_next   = count_reg;
        pending_next = pending_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (do_insert) begin
            count_next = count_reg + CW'(1);
            if (!cell_keep[0]) begin
                pending_next = 1'b1;
            end
        end
        if (do_run) begin
            pending_next = head_done;
            total_next   = wait_sum[TOTAL_W] ? '1 : wait_sum[TOTAL_W-1:0];
            if (head_done) begin
                count_next = count_reg - CW'(1);
            end
        end
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[0]     = do_run;
            m_data_next[8:1]   = do_run ? cell_data[0].id : '0;
            m_data_next[9]     = do_run && pending_reg;
            m_data_next[10]    = do_run && head_done;
            m_data_next[11]    = do_full;
            m_data_next[43:12] = total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pending_reg <= 1'b1;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire
